FILE: hw/rtl/cstrc_pkg.sv
// cstrc_pkg: operation, status and mode codes, payload types and the
// controller/datapath command and status structs of the checksum trace checker
// no dependencies
`default_nettype none

package cstrc_pkg;

    typedef logic [3:0]  t_op;
    typedef logic [2:0]  t_status;
    typedef logic [2:0]  t_mode;
    typedef logic [31:0] t_word;

    localparam t_op OP_CLEAR        = 4'd0;
    localparam t_op OP_LOAD_REF     = 4'd1;
    localparam t_op OP_START_CREATE = 4'd2;
    localparam t_op OP_START_CMP    = 4'd3;
    localparam t_op OP_CHECKSUM     = 4'd4;
    localparam t_op OP_PAUSE        = 4'd5;
    localparam t_op OP_UNPAUSE      = 4'd6;
    localparam t_op OP_IGN_ENTER    = 4'd7;
    localparam t_op OP_IGN_LEAVE    = 4'd8;
    localparam t_op OP_REG_FINISHED = 4'd9;
    localparam t_op OP_READ         = 4'd10;
    localparam t_op OP_FINISHED     = 4'd11;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_ILLEGAL  = 3'd1;
    localparam t_status ST_EXTRA    = 3'd2;
    localparam t_status ST_MISMATCH = 3'd3;
    localparam t_status ST_SHORT    = 3'd4;
    localparam t_status ST_FULL     = 3'd5;
    localparam t_status ST_NEST     = 3'd6;
    localparam t_status ST_RANGE    = 3'd7;

    localparam t_mode M_IDLE  = 3'd0;
    localparam t_mode M_CMP   = 3'd1;
    localparam t_mode M_CRE   = 3'd2;
    localparam t_mode M_CMP_P = 3'd3;
    localparam t_mode M_CRE_P = 3'd4;
    localparam t_mode M_OUT   = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic issue;   // capture word, start store read
        logic exec;    // evaluate word, update state, load result
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // result register can take a new word this cycle
    } t_ctrl_sts;

endpackage

`default_nettype wire

FILE: hw/rtl/cstrc_if.sv
// cstrc_in_if / cstrc_out_if: valid-ready channels for command and result words
// depends on cstrc_pkg
`default_nettype none

interface cstrc_in_if;
    logic                  valid;
    logic                  ready;
    cstrc_pkg::t_op        operation;
    cstrc_pkg::t_word      value;
    logic [11:0]           index;

    modport source (output valid, output operation, output value, output index,
                    input ready);
    modport sink   (input valid, input operation, input value, input index,
                    output ready);
endinterface

interface cstrc_out_if;
    logic                  valid;
    logic                  ready;
    cstrc_pkg::t_status    status;
    cstrc_pkg::t_word      read_data;
    logic [12:0]           entry_count;
    logic [12:0]           position;
    cstrc_pkg::t_word      expected;
    cstrc_pkg::t_mode      mode;
    logic                  ignoring;

    modport source (output valid, output status, output read_data,
                    output entry_count, output position, output expected,
                    output mode, output ignoring, input ready);
    modport sink   (input valid, input status, input read_data,
                    input entry_count, input position, input expected,
                    input mode, input ignoring, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cstrc_ram.sv
// cstrc_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module cstrc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/cstrc_ctrl.sv
// cstrc_ctrl: two-state sequencer, takes a word, then evaluates it once the
// store read is back and the result register is free; depends on cstrc_pkg
`default_nettype none

module cstrc_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire cstrc_pkg::t_ctrl_sts i_sts,
    output cstrc_pkg::t_ctrl_cmd      o_cmd
);

    localparam logic S_WAIT = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd.issue = 1'b0;
        o_cmd.exec  = 1'b0;
        case (r_state)
            S_WAIT: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.issue = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold while the previous result still waits to be taken
                if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_WAIT;
                end
            end
            default: begin
                n_state = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cstrc_dp.sv
// cstrc_dp: mode, count, position and ignore depth registers, the trace store,
// word evaluation and the result register; depends on cstrc_pkg, cstrc_ram
`default_nettype none

module cstrc_dp #(
    parameter int unsigned STORE_DEPTH     = 4096,
    parameter int unsigned MAX_IGNORE_NEST = 15
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire cstrc_pkg::t_ctrl_cmd  i_cmd,
    output cstrc_pkg::t_ctrl_sts       o_sts,
    input  wire cstrc_pkg::t_op        i_operation,
    input  wire cstrc_pkg::t_word      i_value,
    input  wire logic [11:0]           i_index,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output cstrc_pkg::t_status         o_status,
    output cstrc_pkg::t_word           o_read_data,
    output logic [12:0]                o_entry_count,
    output logic [12:0]                o_position,
    output cstrc_pkg::t_word           o_expected,
    output cstrc_pkg::t_mode           o_mode,
    output logic                       o_ignoring
);

    localparam int unsigned AW = $clog2(STORE_DEPTH);
    localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
    localparam int unsigned IW = $clog2(MAX_IGNORE_NEST + 1);

    // captured word
    cstrc_pkg::t_op     r_op;
    cstrc_pkg::t_word   r_val;
    logic [11:0]        r_idx;

    // architectural state
    cstrc_pkg::t_mode   r_mode,  n_mode;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_pos,   n_pos;
    logic [IW-1:0]      r_depth, n_depth;
    // copies of store[pos-1] and store[count-1], valid while pos / count nonzero
    cstrc_pkg::t_word   r_last_match, n_last_match;
    cstrc_pkg::t_word   r_last_store, n_last_store;

    // result register
    logic               r_out_valid;
    cstrc_pkg::t_status r_status;
    cstrc_pkg::t_word   r_read_data;
    logic [12:0]        r_entry_count;
    logic [12:0]        r_position;
    cstrc_pkg::t_word   r_expected;
    cstrc_pkg::t_mode   r_out_mode;
    logic               r_ignoring;

    cstrc_pkg::t_status w_st;
    cstrc_pkg::t_word   w_rd;
    cstrc_pkg::t_word   w_exp;
    logic               w_we;
    cstrc_pkg::t_word   w_rdata;
    logic [AW-1:0]      w_raddr;
    logic               w_full;
    logic               w_idle;

    // read address chosen when the word is taken: read index or compare position
    assign w_raddr = (i_operation == cstrc_pkg::OP_READ) ? AW'(i_index) : AW'(r_pos);

    cstrc_ram #(
        .WIDTH (32),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(r_count)),
        .i_wdata (r_val),
        .i_re    (i_cmd.issue),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_full = (r_count >= CW'(STORE_DEPTH));
    assign w_idle = (r_mode == cstrc_pkg::M_IDLE);

    always_comb begin
        n_mode       = r_mode;
        n_count      = r_count;
        n_pos        = r_pos;
        n_depth      = r_depth;
        n_last_match = r_last_match;
        n_last_store = r_last_store;
        w_st         = cstrc_pkg::ST_OK;
        w_rd         = '0;
        w_exp        = '0;
        w_we         = 1'b0;
        case (r_op)
            cstrc_pkg::OP_CLEAR: begin
                if (!w_idle) begin
                    w_st = cstrc_pkg::ST_ILLEGAL;
                end else begin
                    n_count = '0;
                    n_pos   = '0;
                end
            end
            cstrc_pkg::OP_LOAD_REF: begin
                if (!w_idle) begin
                    w_st = cstrc_pkg::ST_ILLEGAL;
                end else if (w_full) begin
                    w_st = cstrc_pkg::ST_FULL;
                end else begin
                    w_we         = 1'b1;
                    n_count      = r_count + CW'(1);
                    n_last_store = r_val;
                end
            end
            cstrc_pkg::OP_START_CREATE: begin
                if (!w_idle) begin
                    w_st = cstrc_pkg::ST_ILLEGAL;
                end else begin
                    n_count = '0;
                    n_mode  = cstrc_pkg::M_CRE;
                end
            end
            cstrc_pkg::OP_START_CMP: begin
                if (!w_idle) begin
                    w_st = cstrc_pkg::ST_ILLEGAL;
                end else begin
                    n_pos  = '0;
                    n_mode = cstrc_pkg::M_CMP;
                end
            end
            cstrc_pkg::OP_CHECKSUM: begin
                if (r_depth != '0) begin
                    w_st = cstrc_pkg::ST_OK;
                end else if (r_mode == cstrc_pkg::M_CMP) begin
                    // position never passes count while comparing
                    if (r_pos != '0 && r_last_match == r_val) begin
                        w_st = cstrc_pkg::ST_OK;
                    end else if (r_pos >= r_count) begin
                        w_st = cstrc_pkg::ST_EXTRA;
                    end else if (w_rdata != r_val) begin
                        w_st  = cstrc_pkg::ST_MISMATCH;
                        w_exp = w_rdata;
                    end else begin
                        n_pos        = r_pos + CW'(1);
                        n_last_match = r_val;
                    end
                end else if (r_mode == cstrc_pkg::M_CRE) begin
                    if (r_count == '0 || r_last_store != r_val) begin
                        if (w_full) begin
                            w_st = cstrc_pkg::ST_FULL;
                        end else begin
                            w_we         = 1'b1;
                            n_count      = r_count + CW'(1);
                            n_last_store = r_val;
                        end
                    end
                end else begin
                    w_st = cstrc_pkg::ST_ILLEGAL;
                end
            end
            cstrc_pkg::OP_PAUSE: begin
                if (r_mode == cstrc_pkg::M_CMP) begin
                    n_mode = cstrc_pkg::M_CMP_P;
                end else if (r_mode == cstrc_pkg::M_CRE) begin
                    n_mode = cstrc_pkg::M_CRE_P;
                end else begin
                    w_st = cstrc_pkg::ST_ILLEGAL;
                end
            end
            cstrc_pkg::OP_UNPAUSE: begin
                if (r_mode == cstrc_pkg::M_CMP_P) begin
                    n_mode = cstrc_pkg::M_CMP;
                end else if (r_mode == cstrc_pkg::M_CRE_P) begin
                    n_mode = cstrc_pkg::M_CRE;
                end else begin
                    w_st = cstrc_pkg::ST_ILLEGAL;
                end
            end
            cstrc_pkg::OP_IGN_ENTER: begin
                if (r_depth >= IW'(MAX_IGNORE_NEST)) begin
                    w_st = cstrc_pkg::ST_NEST;
                end else begin
                    n_depth = r_depth + IW'(1);
                end
            end
            cstrc_pkg::OP_IGN_LEAVE: begin
                if (r_depth == '0) begin
                    w_st = cstrc_pkg::ST_NEST;
                end else begin
                    n_depth = r_depth - IW'(1);
                end
            end
            cstrc_pkg::OP_REG_FINISHED: begin
                if (r_mode == cstrc_pkg::M_CMP && r_pos != r_count) begin
                    w_st = cstrc_pkg::ST_SHORT;
                end else if (r_mode == cstrc_pkg::M_CMP || r_mode == cstrc_pkg::M_CRE) begin
                    n_mode = cstrc_pkg::M_OUT;
                    n_pos  = '0;
                end else begin
                    w_st = cstrc_pkg::ST_ILLEGAL;
                end
            end
            cstrc_pkg::OP_READ: begin
                if (r_mode != cstrc_pkg::M_OUT) begin
                    w_st = cstrc_pkg::ST_ILLEGAL;
                end else if (32'(r_idx) >= 32'(r_count)) begin
                    w_st = cstrc_pkg::ST_RANGE;
                end else begin
                    w_rd = w_rdata;
                end
            end
            cstrc_pkg::OP_FINISHED: begin
                if (r_mode != cstrc_pkg::M_OUT) begin
                    w_st = cstrc_pkg::ST_ILLEGAL;
                end else begin
                    n_mode = cstrc_pkg::M_IDLE;
                end
            end
            default: begin
                w_st = cstrc_pkg::ST_ILLEGAL;
            end
        endcase
        if (!i_cmd.exec) begin
            w_we = 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_op  <= i_operation;
            r_val <= i_value;
            r_idx <= i_index;
        end
        if (i_cmd.exec) begin
            r_last_match  <= n_last_match;
            r_last_store  <= n_last_store;
            r_status      <= w_st;
            r_read_data   <= w_rd;
            r_entry_count <= 13'(n_count);
            r_position    <= 13'(n_pos);
            r_expected    <= w_exp;
            r_out_mode    <= n_mode;
            r_ignoring    <= (n_depth != '0);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= cstrc_pkg::M_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_mode  <= n_mode;
                r_count <= n_count;
                r_pos   <= n_pos;
                r_depth <= n_depth;
            end
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_read_data   = r_read_data;
    assign o_entry_count = r_entry_count;
    assign o_position    = r_position;
    assign o_expected    = r_expected;
    assign o_mode        = r_out_mode;
    assign o_ignoring    = r_ignoring;

endmodule

`default_nettype wire

FILE: hw/rtl/checksum_trace_record_compare.sv
// checksum_trace_record_compare: top level, joins the sequencer and the datapath
// depends on cstrc_pkg, cstrc_if, cstrc_ctrl, cstrc_dp
//
// Usage:
//   i_in_ch carries command words (operation, value, index); o_out_ch returns
//   exactly one result word per command (status, read_data, entry_count,
//   position, expected, mode, ignoring). Both are valid/ready channels.
//   Taking a command captures it and issues the single read of the trace
//   store RAM (compare position or read index); the execute state then
//   evaluates the command against the registered read data, updates state
//   and loads the result register. A new command is taken only after the
//   last one is evaluated. The last stored and last matched entries are
//   kept in registers, so each command needs only that one store read.
//   The result sits in an output register; the next command is taken while
//   it waits. If the receiver holds ready low, evaluation of the following
//   command waits in the execute state and no further command is taken.
//   Reset (synchronous, active low) returns to idle with empty store count,
//   zero position and zero ignore depth. The store contents are not cleared;
//   only written entries are ever compared or read out.
`default_nettype none

module checksum_trace_record_compare #(
    parameter int unsigned STORE_DEPTH     = 4096,
    parameter int unsigned MAX_IGNORE_NEST = 15
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cstrc_in_if.sink    i_in_ch,
    cstrc_out_if.source o_out_ch
);

    cstrc_pkg::t_ctrl_cmd w_cmd;
    cstrc_pkg::t_ctrl_sts w_sts;
    logic                 w_in_ready;

    cstrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    assign i_in_ch.ready = w_in_ready;

    cstrc_dp #(
        .STORE_DEPTH     (STORE_DEPTH),
        .MAX_IGNORE_NEST (MAX_IGNORE_NEST)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_operation   (i_in_ch.operation),
        .i_value       (i_in_ch.value),
        .i_index       (i_in_ch.index),
        .o_out_valid   (o_out_ch.valid),
        .i_out_ready   (o_out_ch.ready),
        .o_status      (o_out_ch.status),
        .o_read_data   (o_out_ch.read_data),
        .o_entry_count (o_out_ch.entry_count),
        .o_position    (o_out_ch.position),
        .o_expected    (o_out_ch.expected),
        .o_mode        (o_out_ch.mode),
        .o_ignoring    (o_out_ch.ignoring)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/cstrc_chk.sv
// cstrc_chk: port-level checks of the checksum trace checker, bound to the top
// depends on cstrc_pkg, checksum_trace_record_compare
`default_nettype none

module cstrc_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire cstrc_pkg::t_status i_status,
    input wire logic [12:0]        i_entry_count,
    input wire logic [12:0]        i_position,
    input wire cstrc_pkg::t_mode   i_mode
);

    // result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status))
        else $error("result word dropped or changed while stalled");

    // one command in flight: no take in the cycle after a take
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command taken before previous one evaluated");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_mode == cstrc_pkg::M_IDLE |-> i_position == 13'd0)
        else $error("nonzero position in idle");

    a_cmp_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_mode == cstrc_pkg::M_CMP || i_mode == cstrc_pkg::M_CMP_P)
        |-> i_position <= i_entry_count)
        else $error("compare position past entry count");

endmodule

bind checksum_trace_record_compare cstrc_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_ch.valid),
    .i_in_ready    (i_in_ch.ready),
    .i_out_valid   (o_out_ch.valid),
    .i_out_ready   (o_out_ch.ready),
    .i_status      (o_out_ch.status),
    .i_entry_count (o_out_ch.entry_count),
    .i_position    (o_out_ch.position),
    .i_mode        (o_out_ch.mode)
);

`default_nettype wire
